FILE: rtl/sse_data_event_extractor_defines.svh
// assertion macros shared by the sse data event extractor rtl
// no dependencies; included by the modules that carry assertions
`ifndef SSE_DATA_EVENT_EXTRACTOR_DEFINES_SVH
`define SSE_DATA_EVENT_EXTRACTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDEE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdee assertion failed");

// next-cycle implication, checked outside reset
`define SDEE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdee assertion failed");

`endif

FILE: rtl/sdee_pkg.sv
// shared types and constants for the sse data event extractor
// used by sdee_ctrl, sdee_datapath and the top level
package sdee_pkg;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [2:0] PREFIX_LEN   = 3'd6;

    typedef enum logic [1:0] {
        PH_SEEK    = 2'd0,
        PH_COLLECT = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    // controller to datapath
    typedef struct packed {
        logic step;   // consume the input byte
        logic clear;  // start a fresh block
        logic rd;     // read store entry at read index
        logic next;   // advance read index
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic blk_end;     // input byte closes the block
        logic has_event;   // prefix seen in this block
        logic count_zero;  // no payload bytes stored
        logic is_last;     // current output is the final one
    } t_dp_status;

    // bytes of "data: "
    function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h64;  // d
            3'd1:    b = 8'h61;  // a
            3'd2:    b = 8'h74;  // t
            3'd3:    b = 8'h61;  // a
            3'd4:    b = 8'h3A;  // :
            3'd5:    b = 8'h20;  // space
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/sdee_datapath.sv
// datapath of the sse data event extractor: prefix matcher, block tracking,
// payload store and output fields; depends on sdee_pkg
`include "sse_data_event_extractor_defines.svh"

module sdee_datapath
    import sdee_pkg::*;
#(
    parameter int DATA_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_in_byte,
    output t_dp_status o_status,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last,
    output logic       o_truncated
);

    localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int CW = $clog2(DATA_DEPTH + 1);

    logic [7:0]    r_mem [DATA_DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_idx, n_idx;
    logic [2:0]    r_match, n_match;
    t_phase        r_phase, n_phase;
    logic          r_prev_nl, n_prev_nl;
    logic [CW-1:0] r_count, n_count;
    logic          r_overflow, n_overflow;

    logic          is_nl;
    logic          mem_we;
    logic [2:0]    match_inc;

    assign is_nl     = (i_in_byte == NEWLINE_BYTE);
    assign match_inc = 3'(r_match + 3'd1);

    assign o_status.blk_end    = is_nl && r_prev_nl;
    assign o_status.has_event  = (r_phase != PH_SEEK);
    assign o_status.count_zero = (r_count == '0);
    assign o_status.is_last    = (r_count == '0) ||
                                 (CW'(CW'(r_idx) + CW'(1)) == r_count);

    assign o_out_byte   = (r_count == '0) ? 8'h00 : r_rd_data;
    assign o_byte_valid = (r_count != '0);
    assign o_last       = o_status.is_last;
    assign o_truncated  = r_overflow;

    assign mem_we = i_cmd.step && !is_nl && (r_phase == PH_COLLECT) &&
                    (r_count < CW'(DATA_DEPTH));

    always_comb begin
        n_match    = r_match;
        n_phase    = r_phase;
        n_prev_nl  = r_prev_nl;
        n_count    = r_count;
        n_overflow = r_overflow;
        n_idx      = r_idx;
        if (i_cmd.clear) begin
            n_match    = '0;
            n_phase    = PH_SEEK;
            n_prev_nl  = 1'b0;
            n_count    = '0;
            n_overflow = 1'b0;
            n_idx      = '0;
        end else if (i_cmd.step && !o_status.blk_end) begin
            if (is_nl) begin
                n_prev_nl = 1'b1;
                n_match   = '0;
                if (r_phase == PH_COLLECT) begin
                    n_phase = PH_DONE;
                end
            end else begin
                n_prev_nl = 1'b0;
                case (r_phase)
                    PH_SEEK: begin
                        if (i_in_byte == prefix_byte(r_match)) begin
                            n_match = match_inc;
                        end else begin
                            n_match = (i_in_byte == prefix_byte(3'd0)) ? 3'd1 : 3'd0;
                        end
                        if ((i_in_byte == prefix_byte(r_match)) &&
                            (match_inc == PREFIX_LEN)) begin
                            n_phase    = PH_COLLECT;
                            n_match    = '0;
                            n_count    = '0;
                            n_overflow = 1'b0;
                        end
                    end
                    PH_COLLECT: begin
                        if (r_count < CW'(DATA_DEPTH)) begin
                            n_count = CW'(r_count + CW'(1));
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else if (i_cmd.next) begin
            n_idx = AW'(r_idx + AW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= '0;
            r_phase    <= PH_SEEK;
            r_prev_nl  <= 1'b0;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_match    <= n_match;
            r_phase    <= n_phase;
            r_prev_nl  <= n_prev_nl;
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_idx      <= n_idx;
        end
    end

    // payload store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AW-1:0]] <= i_in_byte;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    `SDEE_ASSERT_IMP(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(DATA_DEPTH))
    `SDEE_ASSERT_IMP(a_overflow_full, i_clk, i_rst_n, r_overflow, r_count == CW'(DATA_DEPTH))
    `SDEE_ASSERT_NXT(a_clear_resets, i_clk, i_rst_n, i_cmd.clear, r_count == '0 && r_phase == PH_SEEK)

endmodule

FILE: rtl/sdee_ctrl.sv
// controller of the sse data event extractor: intake, store read and output
// sequencing; depends on sdee_pkg
`include "sse_data_event_extractor_defines.svh"

module sdee_ctrl
    import sdee_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_INTAKE = 3'b001,
        ST_READ   = 3'b010,
        ST_OUT    = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic   emit_start;
    logic   emit_end;

    assign o_ready = (r_state == ST_INTAKE);
    assign o_valid = (r_state == ST_OUT);

    assign emit_start = i_valid && o_ready && i_status.blk_end && i_status.has_event;
    assign emit_end   = o_valid && i_ready && i_status.is_last;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_INTAKE: begin
                if (i_valid) begin
                    o_cmd.step = 1'b1;
                    if (i_status.blk_end) begin
                        if (!i_status.has_event) begin
                            o_cmd.clear = 1'b1;
                        end else if (i_status.count_zero) begin
                            n_state = ST_OUT;
                        end else begin
                            n_state = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (i_ready) begin
                    if (i_status.is_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_INTAKE;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_INTAKE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INTAKE;
        end else begin
            r_state <= n_state;
        end
    end

    // a block end with an event stops intake for the emission
    `SDEE_ASSERT_NXT(a_emit_stalls_intake, i_clk, i_rst_n, emit_start, !o_ready)
    // intake resumes only after the final transaction of an event
    `SDEE_ASSERT_NXT(a_last_resumes, i_clk, i_rst_n, emit_end, o_ready)

endmodule

FILE: rtl/sse_data_event_extractor.sv
// Server-sent-events data extractor. Input bytes are taken one per cycle while
// a block is being scanned; a byte pair of two newlines closes the block. If
// the block held "data: ", the bytes after it up to the next newline are then
// emitted as one event, one payload byte per output transaction with o_last on
// the final one and o_truncated set on all of them when the payload exceeded
// DATA_DEPTH bytes; an empty payload gives a single transaction with
// o_byte_valid low. During emission intake is stalled: each payload byte takes
// a registered read of the payload store, then the output transaction, and
// intake also stays stalled through any output backpressure. Blocks without
// the prefix emit nothing and never stall intake. No clearing pass after reset.
// Depends on sdee_pkg, sdee_ctrl and sdee_datapath.
module sse_data_event_extractor
    import sdee_pkg::*;
#(
    parameter int DATA_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last,
    output logic       o_truncated
);

    t_dp_cmd    cmd;
    t_dp_status status;

    sdee_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sdee_datapath #(
        .DATA_DEPTH (DATA_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_in_byte    (i_in_byte),
        .o_status     (status),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_truncated  (o_truncated)
    );

endmodule
